>>> rtl/allocation_bitmap_run_splitter_assert.svh
// assertion helpers included by abrs_back.sv
`ifndef ALLOCATION_BITMAP_RUN_SPLITTER_ASSERT_SVH
`define ALLOCATION_BITMAP_RUN_SPLITTER_ASSERT_SVH

// same-cycle implication
`define ABRS_ASSERT_NOW(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("abrs check failed");

// next-cycle implication
`define ABRS_ASSERT_NEXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("abrs check failed");

`endif

>>> rtl/abrs_pkg.sv
package abrs_pkg;

	localparam int WORD_BITS = 64;
	// word index wide enough for the largest map
	localparam int WIDX_W = 17;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	localparam logic [1:0] OP_READ      = 2'd0;
	localparam logic [1:0] OP_WRITE_NEW = 2'd1;
	localparam logic [1:0] OP_OVERWRITE = 2'd2;

	typedef enum logic [1:0] {
		K_LOAD,
		K_READ,
		K_ERROR,
		K_SPLIT
	} kind_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [9:0]  word_index;
		logic [63:0] word_data;
		logic [15:0] start_lbid;
		logic [6:0]  lbid_count;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  seg_op;
		logic [15:0] seg_start;
		logic [6:0]  seg_length;
		logic        last;
		logic        error;
	} res_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [WIDX_W-1:0]  widx;
		logic [63:0]        data;
		logic [15:0]        start;
		logic [6:0]         count;
	} job_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_RD_LO,
		B_RD_HI,
		B_RUN
	} bstate_t;

endpackage

>>> rtl/abrs_ram.sv
module abrs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/abrs_fifo.sv
module abrs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/abrs_front.sv
module abrs_front #(
	parameter int MAP_WORDS   = 1024,
	parameter int MAX_REQUEST = 64
) (
	input  logic                 push,
	input  abrs_pkg::in_item_t   item,
	input  logic                 job_full,
	input  logic                 clearing,
	output logic                 full,
	output logic                 job_push,
	output abrs_pkg::job_t       job
);

	localparam int MAP_BITS = MAP_WORDS * abrs_pkg::WORD_BITS;

	logic [6:0]  count_sat;
	logic [16:0] end_sum;
	logic        over;
	logic        load_ok;
	logic        keep;

	assign count_sat = (item.lbid_count > 7'(MAX_REQUEST)) ? 7'(MAX_REQUEST) : item.lbid_count;
	assign end_sum   = {1'b0, item.start_lbid} + {10'b0, count_sat};
	assign over      = {15'b0, end_sum} > 32'(MAP_BITS);
	assign load_ok   = {7'b0, item.word_index} < 17'(MAP_WORDS);

	always_comb begin
		keep      = 1'b0;
		job.kind  = abrs_pkg::K_LOAD;
		// loads address the given word, requests the word holding the first block
		job.widx  = {7'b0, item.start_lbid[15:6]};
		job.data  = item.word_data;
		job.start = item.start_lbid;
		job.count = count_sat;
		case (item.cmd)
			abrs_pkg::CMD_LOAD: begin
				keep     = load_ok;
				job.kind = abrs_pkg::K_LOAD;
				job.widx = {7'b0, item.word_index};
			end
			abrs_pkg::CMD_READ: begin
				keep     = (count_sat != '0);
				job.kind = over ? abrs_pkg::K_ERROR : abrs_pkg::K_READ;
			end
			abrs_pkg::CMD_WRITE: begin
				keep     = (count_sat != '0);
				job.kind = over ? abrs_pkg::K_ERROR : abrs_pkg::K_SPLIT;
			end
			default: begin
				keep     = 1'b0;
				job.kind = abrs_pkg::K_LOAD;
			end
		endcase
	end

	assign full     = job_full | clearing;
	assign job_push = push & ~full & keep;

endmodule

>>> rtl/abrs_back.sv
module abrs_back #(
	parameter int MAP_WORDS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  abrs_pkg::job_t       job,
	output logic                 job_pop,
	output logic                 res_push,
	output abrs_pkg::res_item_t  res,
	input  logic                 res_full,
	output logic                 clearing
);

	`include "allocation_bitmap_run_splitter_assert.svh"

	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	abrs_pkg::bstate_t state_q;
	abrs_pkg::bstate_t state_d;

	logic [AW-1:0]               clr_q;
	logic [15:0]                 pos_q;
	logic [6:0]                  rem_q;
	logic [5:0]                  off_q;
	logic [abrs_pkg::WIDX_W-1:0] hi_idx_q;
	logic [63:0]                 lo_q;
	logic [63:0]                 win_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [63:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [63:0]   ram_rdata;

	logic [63:0] diff;
	logic [63:0] low_bit;
	logic [6:0]  first_enc;
	logic [6:0]  first;
	logic [6:0]  seg_len;
	logic        seg_last;

	abrs_ram #(
		.WIDTH(64),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// window bit 0 is the current block; the run ends at the first differing bit
	assign diff    = win_q ^ {64{win_q[0]}};
	assign low_bit = diff & (~diff + 64'd1);

	always_comb begin
		first_enc = '0;
		for (int i = 0; i < 64; i++) begin
			first_enc = first_enc | (low_bit[i] ? 7'(i) : 7'd0);
		end
	end

	assign first    = (diff == '0) ? 7'd64 : first_enc;
	assign seg_len  = (first < rem_q) ? first : rem_q;
	assign seg_last = (seg_len == rem_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			abrs_pkg::B_CLEAR: begin
				if (clr_q == AW'(MAP_WORDS - 1)) begin
					state_d = abrs_pkg::B_IDLE;
				end
			end
			abrs_pkg::B_IDLE: begin
				if (job_valid && job.kind == abrs_pkg::K_SPLIT) begin
					state_d = abrs_pkg::B_RD_LO;
				end
			end
			abrs_pkg::B_RD_LO: begin
				state_d = abrs_pkg::B_RD_HI;
			end
			abrs_pkg::B_RD_HI: begin
				state_d = abrs_pkg::B_RUN;
			end
			abrs_pkg::B_RUN: begin
				if (!res_full && seg_last) begin
					state_d = abrs_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = abrs_pkg::B_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		job_pop   = 1'b0;
		res_push  = 1'b0;
		res       = '0;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_raddr = job.widx[AW-1:0];
		clearing  = 1'b0;
		case (state_q)
			abrs_pkg::B_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				clearing  = 1'b1;
			end
			abrs_pkg::B_IDLE: begin
				res.seg_op     = abrs_pkg::OP_READ;
				res.seg_start  = job.start;
				res.seg_length = job.count;
				res.last       = 1'b1;
				res.error      = (job.kind == abrs_pkg::K_ERROR);
				if (job_valid) begin
					case (job.kind)
						abrs_pkg::K_LOAD: begin
							ram_we    = 1'b1;
							ram_waddr = job.widx[AW-1:0];
							ram_wdata = job.data;
							job_pop   = 1'b1;
						end
						abrs_pkg::K_READ, abrs_pkg::K_ERROR: begin
							res_push = ~res_full;
							job_pop  = ~res_full;
						end
						abrs_pkg::K_SPLIT: begin
							job_pop = 1'b1;
						end
						default: begin
							job_pop = 1'b0;
						end
					endcase
				end
			end
			abrs_pkg::B_RD_LO: begin
				ram_raddr = hi_idx_q[AW-1:0];
			end
			abrs_pkg::B_RUN: begin
				res.seg_op     = win_q[0] ? abrs_pkg::OP_OVERWRITE : abrs_pkg::OP_WRITE_NEW;
				res.seg_start  = pos_q;
				res.seg_length = seg_len;
				res.last       = seg_last;
				res.error      = 1'b0;
				res_push       = ~res_full;
			end
			default: begin
				job_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abrs_pkg::B_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == abrs_pkg::B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			abrs_pkg::B_IDLE: begin
				if (job_valid && job.kind == abrs_pkg::K_SPLIT) begin
					pos_q    <= job.start;
					rem_q    <= job.count;
					off_q    <= job.start[5:0];
					hi_idx_q <= job.widx + abrs_pkg::WIDX_W'(1);
				end
			end
			abrs_pkg::B_RD_LO: begin
				lo_q <= ram_rdata;
			end
			abrs_pkg::B_RD_HI: begin
				// two words side by side, aligned so the first block sits at bit 0
				win_q <= 64'({ram_rdata, lo_q} >> off_q);
			end
			abrs_pkg::B_RUN: begin
				if (!res_full) begin
					pos_q <= pos_q + {9'b0, seg_len};
					rem_q <= rem_q - seg_len;
					win_q <= win_q >> seg_len;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	`ABRS_ASSERT_NOW(a_no_push_when_full, clk, arst_n, res_push, !res_full)
	`ABRS_ASSERT_NOW(a_seg_len_in_range, clk, arst_n, state_q == abrs_pkg::B_RUN, seg_len != 7'd0 && seg_len <= rem_q)
	`ABRS_ASSERT_NEXT(a_last_ends_run, clk, arst_n, state_q == abrs_pkg::B_RUN && res_push && seg_last, state_q == abrs_pkg::B_IDLE)
	`ABRS_ASSERT_NOW(a_no_job_while_clearing, clk, arst_n, clearing, !job_pop && !res_push)

endmodule

>>> rtl/allocation_bitmap_run_splitter.sv
// Allocation bitmap run splitter. A load item writes its bitmap word in the back end;
// a read request or an out-of-range request gives its single result. A write request
// steps through B_IDLE, B_RD_LO and B_RD_HI to fetch the two bitmap words around its
// range through the single read port of the bitmap memory, then the segment sequencer
// emits its 1 to MAX_REQUEST segments, one run a cycle unless the result queue is
// full. A two-entry command queue sits behind the input and a two-entry result queue
// in front of the output, so items keep arriving while results wait to be popped.
// After reset the whole bitmap is cleared one word a cycle, with full held high.
module allocation_bitmap_run_splitter #(
	parameter int MAP_WORDS   = 1024,
	parameter int MAX_REQUEST = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  abrs_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output abrs_pkg::res_item_t result
);

	localparam int JOB_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	abrs_pkg::job_t      job_in;
	abrs_pkg::job_t      job_head;
	abrs_pkg::res_item_t res_in;
	logic                job_push;
	logic                job_full;
	logic                job_empty;
	logic                job_pop;
	logic                res_push;
	logic                res_full;
	logic                clearing;

	abrs_front #(
		.MAP_WORDS  (MAP_WORDS),
		.MAX_REQUEST(MAX_REQUEST)
	) u_front (
		.push    (push),
		.item    (item),
		.job_full(job_full),
		.clearing(clearing),
		.full    (full),
		.job_push(job_push),
		.job     (job_in)
	);

	abrs_fifo #(
		.WIDTH($bits(abrs_pkg::job_t)),
		.DEPTH(JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_data(job_in),
		.full   (job_full),
		.rd_en  (job_pop),
		.rd_data(job_head),
		.empty  (job_empty)
	);

	abrs_back #(
		.MAP_WORDS(MAP_WORDS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(~job_empty),
		.job      (job_head),
		.job_pop  (job_pop),
		.res_push (res_push),
		.res      (res_in),
		.res_full (res_full),
		.clearing (clearing)
	);

	abrs_fifo #(
		.WIDTH($bits(abrs_pkg::res_item_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(result),
		.empty  (empty)
	);

endmodule

>>> verif/allocation_bitmap_run_splitter_test.sv
module allocation_bitmap_run_splitter_test;
	timeunit 1ns;
	timeprecision 1ps;
	import abrs_pkg::*;

	localparam int MAP_WORDS   = 1024;
	localparam int MAX_REQ     = 64;
	localparam int MAP_BITS    = MAP_WORDS * WORD_BITS;
	localparam int N_RANDOM    = 130;
	localparam int LONG_HOLD   = 400;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	res_item_t result;

	allocation_bitmap_run_splitter #(
		.MAP_WORDS(MAP_WORDS),
		.MAX_REQUEST(MAX_REQ)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	typedef struct {
		in_item_t  it;
		bit        typed;
		res_item_t seg;
	} dir_row_t;

	dir_row_t    dir_rows[$];
	res_item_t   expected_segs[$];
	logic [63:0] bitmap_img [MAP_WORDS];
	int          fail_count = 0;
	bit          quiet = 1'b0;
	bit          keep_offering = 1'b0;
	bit          long_hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("** allocation_bitmap_run_splitter: FAILED **");
		$finish;
	end

	function automatic in_item_t mk_item(logic [1:0] cmd, logic [9:0] widx, logic [63:0] data,
			logic [15:0] start, logic [6:0] count);
		in_item_t it;
		it.cmd        = cmd;
		it.word_index = widx;
		it.word_data  = data;
		it.start_lbid = start;
		it.lbid_count = count;
		return it;
	endfunction

	function automatic res_item_t mk_seg(logic [1:0] op, logic [15:0] start, logic [6:0] len,
			logic last, logic err);
		res_item_t r;
		r.seg_op     = op;
		r.seg_start  = start;
		r.seg_length = len;
		r.last       = last;
		r.error      = err;
		return r;
	endfunction

	task automatic add_row(input in_item_t it, input bit typed, input res_item_t seg);
		dir_row_t row;
		row.it    = it;
		row.typed = typed;
		row.seg   = seg;
		dir_rows.push_back(row);
	endtask

	// applies an item to the bitmap image: loads update it, requests append the results they must produce
	function automatic void predict_segments(in_item_t it);
		int        cnt;
		int        st;
		int        pos;
		int        run_st;
		bit        run_b;
		bit        b;
		bit        at_end;
		res_item_t r;
		cnt = (it.lbid_count > MAX_REQ) ? MAX_REQ : int'(it.lbid_count);
		st  = int'(it.start_lbid);
		b   = 1'b0;
		case (it.cmd)
			CMD_LOAD: begin
				if (int'(it.word_index) < MAP_WORDS)
					bitmap_img[it.word_index] = it.word_data;
			end
			CMD_READ, CMD_WRITE: begin
				if (cnt == 0) begin
					// nothing comes back for an empty request
				end else if (st + cnt > MAP_BITS) begin
					expected_segs.push_back(mk_seg(OP_READ, 16'(st), 7'(cnt), 1'b1, 1'b1));
				end else if (it.cmd == CMD_READ) begin
					expected_segs.push_back(mk_seg(OP_READ, 16'(st), 7'(cnt), 1'b1, 1'b0));
				end else begin
					run_st = st;
					run_b  = bitmap_img[st / WORD_BITS][st % WORD_BITS];
					for (pos = st + 1; pos <= st + cnt; pos++) begin
						at_end = (pos == st + cnt);
						if (!at_end)
							b = bitmap_img[pos / WORD_BITS][pos % WORD_BITS];
						if (at_end || b != run_b) begin
							r = mk_seg(run_b ? OP_OVERWRITE : OP_WRITE_NEW, 16'(run_st),
								7'(pos - run_st), at_end, 1'b0);
							expected_segs.push_back(r);
							run_st = pos;
							run_b  = b;
						end
					end
				end
			end
			default: begin
				// unused command is dropped
			end
		endcase
	endfunction

	task automatic send_item(input in_item_t it);
		item <= it;
		push <= 1'b1;
		do @(posedge clk); while (full !== 1'b0);
	endtask

	task automatic sender_pause();
		if (!quiet && !keep_offering && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// result side: checks each transfer, then picks pop for the next edge
	initial begin
		res_item_t want;
		int        stall_left;
		stall_left = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (expected_segs.size() == 0) begin
					$error("segment with nothing expected: op %0d start %0d len %0d",
						result.seg_op, result.seg_start, result.seg_length);
					fail_count++;
				end else begin
					want = expected_segs.pop_front();
					if (result.seg_op !== want.seg_op) begin
						$error("seg_op: expected %0d, got %0d", want.seg_op, result.seg_op);
						fail_count++;
					end
					if (result.seg_start !== want.seg_start) begin
						$error("seg_start: expected %0d, got %0d", want.seg_start,
							result.seg_start);
						fail_count++;
					end
					if (result.seg_length !== want.seg_length) begin
						$error("seg_length: expected %0d, got %0d", want.seg_length,
							result.seg_length);
						fail_count++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, result.last);
						fail_count++;
					end
					if (result.error !== want.error) begin
						$error("error: expected %0d, got %0d", want.error, result.error);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// input side: directed table, then random traffic
	initial begin
		in_item_t it;
		int       n_done;
		int       hot_base;
		int       sel;
		int       sh;
		bit       ignored;

		push   <= 1'b0;
		item   <= '0;
		arst_n <= 1'b0;
		foreach (bitmap_img[i])
			bitmap_img[i] = '0;

		// freshly cleared map: whole word is one write-new run
		add_row(mk_item(CMD_WRITE, 10'd0, 64'd0, 16'd0, 7'd64), 1'b1,
			mk_seg(OP_WRITE_NEW, 16'd0, 7'd64, 1'b1, 1'b0));
		add_row(mk_item(CMD_READ, 10'd0, 64'd0, 16'd100, 7'd5), 1'b1,
			mk_seg(OP_READ, 16'd100, 7'd5, 1'b1, 1'b0));
		add_row(mk_item(CMD_READ, 10'd0, 64'd0, 16'hFFFF, 7'd1), 1'b1,
			mk_seg(OP_READ, 16'hFFFF, 7'd1, 1'b1, 1'b0));
		// past the end of the map
		add_row(mk_item(CMD_WRITE, 10'd0, 64'd0, 16'hFFFF, 7'd2), 1'b1,
			mk_seg(OP_READ, 16'hFFFF, 7'd2, 1'b1, 1'b1));
		add_row(mk_item(CMD_READ, 10'd0, 64'd0, 16'd65500, 7'd100), 1'b1,
			mk_seg(OP_READ, 16'd65500, 7'd64, 1'b1, 1'b1));
		// oversized count saturates
		add_row(mk_item(CMD_READ, 10'd0, 64'd0, 16'd0, 7'd127), 1'b1,
			mk_seg(OP_READ, 16'd0, 7'd64, 1'b1, 1'b0));
		add_row(mk_item(CMD_WRITE, 10'h3FF, '1, 16'd200, 7'd0), 1'b0, '0);
		add_row(mk_item(CMD_READ, 10'h3FF, '1, 16'hFFFF, 7'd0), 1'b0, '0);
		add_row(mk_item(CMD_UNUSED, 10'h3FF, '1, 16'hFFFF, 7'h7F), 1'b0, '0);
		add_row(mk_item(CMD_LOAD, 10'd0, '1, 16'd0, 7'd0), 1'b0, '0);
		add_row(mk_item(CMD_LOAD, 10'd1, 64'h5555_5555_5555_5555, 16'd0, 7'd0), 1'b0, '0);
		add_row(mk_item(CMD_WRITE, 10'd0, 64'd0, 16'd0, 7'd64), 1'b0, '0);
		add_row(mk_item(CMD_WRITE, 10'd0, 64'd0, 16'd32, 7'd64), 1'b0, '0);
		add_row(mk_item(CMD_WRITE, 10'd0, 64'd0, 16'd64, 7'd64), 1'b0, '0);
		add_row(mk_item(CMD_WRITE, 10'd0, 64'd0, 16'd10, 7'd127), 1'b0, '0);
		add_row(mk_item(CMD_LOAD, 10'h3FF, 64'h8000_0000_0000_0001, 16'd0, 7'd0), 1'b0, '0);
		add_row(mk_item(CMD_WRITE, 10'd0, 64'd0, 16'd65472, 7'd64), 1'b0, '0);
		add_row(mk_item(CMD_LOAD, 10'h3FF, '1, 16'd0, 7'd0), 1'b0, '0);
		add_row(mk_item(CMD_WRITE, 10'd0, 64'd0, 16'hFFFF, 7'd1), 1'b0, '0);
		add_row(mk_item(CMD_LOAD, 10'd512, 64'hFFFF_FFFF_0000_0000, 16'd0, 7'd0), 1'b0, '0);
		add_row(mk_item(CMD_WRITE, 10'd0, 64'd0, 16'd32784, 7'd64), 1'b0, '0);
		add_row(mk_item(CMD_WRITE, 10'd0, 64'd0, 16'd1, 7'd1), 1'b0, '0);
		add_row(mk_item(CMD_LOAD, 10'd1, 64'd0, 16'd0, 7'd0), 1'b0, '0);
		add_row(mk_item(CMD_WRITE, 10'd0, 64'd0, 16'd63, 7'd2), 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].it);
			if (dir_rows[i].typed)
				expected_segs.push_back(dir_rows[i].seg);
			else
				predict_segments(dir_rows[i].it);
			sender_pause();
		end

		n_done   = 0;
		hot_base = $urandom_range(0, MAP_WORDS - 8);
		while (n_done < N_RANDOM) begin
			it.cmd        = 2'($urandom);
			it.word_index = 10'($urandom);
			it.word_data  = {$urandom, $urandom};
			it.start_lbid = 16'($urandom);
			it.lbid_count = 7'($urandom);
			if ($urandom_range(0, 15) == 0)
				hot_base = $urandom_range(0, MAP_WORDS - 8);
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				it.cmd = CMD_LOAD;
				if ($urandom_range(0, 3) != 0)
					it.word_index = 10'(hot_base + $urandom_range(0, 7));
				sh = $urandom_range(0, 63);
				case ($urandom_range(0, 4))
					0: it.word_data = {$urandom, $urandom} & {$urandom, $urandom};
					1: it.word_data = {$urandom, $urandom} | {$urandom, $urandom};
					2: it.word_data = $urandom_range(0, 1) ? '1 : '0;
					3: it.word_data = ~64'd0 << sh;
					default: ;
				endcase
			end else if (sel < 93) begin
				it.cmd = (sel < 80) ? CMD_WRITE : CMD_READ;
				if ($urandom_range(0, 4) != 0)
					it.start_lbid = 16'((hot_base + $urandom_range(0, 7)) * WORD_BITS
						+ $urandom_range(0, 63));
				case ($urandom_range(0, 9))
					0: it.lbid_count = 7'($urandom_range(65, 127));
					1: it.lbid_count = 7'd0;
					default: it.lbid_count = 7'($urandom_range(1, 64));
				endcase
			end else if (sel < 96) begin
				it.cmd = CMD_UNUSED;
			end else begin
				it.cmd        = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
				it.start_lbid = 16'(MAP_BITS - $urandom_range(1, 64));
				it.lbid_count = 7'($urandom_range(1, 127));
			end
			ignored = (it.cmd == CMD_UNUSED) || (it.cmd != CMD_LOAD && it.lbid_count == 0);

			send_item(it);
			predict_segments(it);
			if (!ignored)
				n_done++;

			if (n_done == 40 && !ignored) begin
				// receiver goes away while the sender keeps offering
				long_hold_req = 1'b1;
				keep_offering = 1'b1;
			end
			if (n_done == 70)
				keep_offering = 1'b0;
			if (n_done >= N_RANDOM - 30)
				quiet = 1'b1;

			if (n_done == 100 && !ignored) begin
				push <= 1'b0;
				while (expected_segs.size() != 0)
					@(posedge clk);
			end else begin
				sender_pause();
			end
		end

		push <= 1'b0;
		while (expected_segs.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("** allocation_bitmap_run_splitter: PASSED **");
		else
			$display("** allocation_bitmap_run_splitter: FAILED **");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/abrs_pkg.sv
rtl/abrs_ram.sv
rtl/abrs_fifo.sv
rtl/abrs_front.sv
rtl/abrs_back.sv
rtl/allocation_bitmap_run_splitter.sv
verif/allocation_bitmap_run_splitter_test.sv
